@@ rtl/core/snpt_pkg.sv @@
// Shared types, constants and the arctangent table for the sector nearest-point tracker.
package snpt_pkg;

  // Angle format: Q2.13 radians, two's complement.
  localparam int ANGLE_W      = 16;
  // CORDIC phase accumulator: Q.16 radians, wide enough for +-(pi/2 + sum of table).
  localparam int PHASE_W      = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  // Inputs are scaled by 2^12 before the iterations.
  localparam int GUARD_SHIFT  = 12;
  // Extra datapath bits above the coordinate width: guard shift, gain and sign.
  localparam int CORDIC_EXTRA = 15;

  localparam logic signed [PHASE_W-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [ANGLE_W-1:0] PI_Q13      = 16'sd25736;

  // Configuration registers.
  localparam int CHW_W  = 14;
  localparam int MELV_W = 15;
  localparam int CFG_DATA_W = 15;
  localparam logic CFG_CENTER_HALF_WIDTH = 1'b0;
  localparam logic CFG_MIN_ELEVATION     = 1'b1;
  localparam logic [CHW_W-1:0]  CHW_RESET  = 14'd2130;
  localparam logic [MELV_W-1:0] MELV_RESET = 15'd12288;

  // Sector classification of one bearing.
  typedef struct packed {
    logic positive;
    logic center;
    logic negative;
  } snpt_sector_hit_t;

  // atan(2^-i) in Q.16 radians.
  function automatic logic signed [PHASE_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic signed [PHASE_W-1:0] v;
    unique case (i)
      4'd0:  v = 20'sd51472;
      4'd1:  v = 20'sd30385;
      4'd2:  v = 20'sd16055;
      4'd3:  v = 20'sd8150;
      4'd4:  v = 20'sd4091;
      4'd5:  v = 20'sd2047;
      4'd6:  v = 20'sd1024;
      4'd7:  v = 20'sd512;
      4'd8:  v = 20'sd256;
      4'd9:  v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      4'd15: v = 20'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/sector_nearest_point_tracker.sv @@
// Sector nearest-point tracker: elevation gate, bearing sectors and per-sector minimum range.
// Each point transaction runs the elevation pass, then, for a point that passes the elevation
// gate, the bearing pass, then the sector update; one shared 16-step CORDIC serves both passes.
// A new point is taken only once the previous one is done; the range root runs
// alongside the first CORDIC pass. A last point also goes through the emit state, and its
// result is loaded into the output register once that register is not held.
// Reset (synchronous, active high) restores the registers to their defaults, clears the
// sector minima to all ones and the found flags to zero, and drops any pending result.
module sector_nearest_point_tracker import snpt_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         point_valid,
  output logic                         point_stall,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic                         last_point,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [COORD_WIDTH-1:0]       positive_range,
  output logic                         positive_found,
  output logic [COORD_WIDTH-1:0]       center_range,
  output logic                         center_found,
  output logic [COORD_WIDTH-1:0]       negative_range,
  output logic                         negative_found
);

  localparam int W = COORD_WIDTH;

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_ELEV_START = 3'd1;
  localparam logic [2:0] S_ELEV_WAIT  = 3'd2;
  localparam logic [2:0] S_BEAR_START = 3'd3;
  localparam logic [2:0] S_BEAR_WAIT  = 3'd4;
  localparam logic [2:0] S_UPDATE     = 3'd5;
  localparam logic [2:0] S_EMIT       = 3'd6;

  logic [2:0]          state;
  logic [CHW_W-1:0]    center_half_width;
  logic [MELV_W-1:0]   min_elevation;
  logic signed [W-1:0] px;
  logic signed [W-1:0] py;
  logic signed [W-1:0] pz;
  logic                last;
  logic                bear_sel;
  logic                passed;
  logic                bear_ready;
  logic signed [ANGLE_W-1:0] bearing;
  logic [W-1:0]        sector_minimum [3];
  logic [2:0]          sector_seen;

  logic                      cordic_start;
  logic signed [W-1:0]       cordic_a;
  logic signed [W-1:0]       cordic_b;
  logic                      cordic_done;
  logic signed [ANGLE_W-1:0] cordic_angle;
  logic                      root_valid;
  logic [W-1:0]              root_range;

  logic                      point_take;
  logic                      result_free;
  logic signed [ANGLE_W-1:0] thr;
  logic signed [ANGLE_W-1:0] min_elev_s;
  snpt_sector_hit_t          hit;
  logic [2:0]                hit_vec;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_half_width <= CHW_RESET;
      min_elevation     <= MELV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER_HALF_WIDTH: center_half_width <= cfg_data[CHW_W-1:0];
        CFG_MIN_ELEVATION:     min_elevation     <= cfg_data[MELV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input transaction and output register handshake.
  assign point_stall = (state != S_IDLE);
  assign point_take  = point_valid && !point_stall;
  assign result_free = !result_valid || !result_stall;

  // The shared CORDIC first measures elevation atan2(z, y), then bearing atan2(x, z).
  assign cordic_start = (state == S_ELEV_START) || (state == S_BEAR_START);
  assign cordic_a     = bear_sel ? px : pz;
  assign cordic_b     = bear_sel ? pz : py;

  snpt_cordic #(.W(W)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .a     (cordic_a),
    .b     (cordic_b),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  snpt_sqrt #(.W(W)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_ELEV_START),
    .a     (pz),
    .b     (px),
    .valid (root_valid),
    .range (root_range)
  );

  // Sector classification; a bearing on a boundary hits nothing.
  assign thr        = $signed({{(ANGLE_W-CHW_W){1'b0}}, center_half_width});
  assign min_elev_s = $signed({{(ANGLE_W-MELV_W){1'b0}}, min_elevation});

  always_comb begin
    hit.positive = bearing > thr;
    hit.center   = (bearing > -thr) && (bearing < thr);
    hit.negative = bearing < -thr;
    hit_vec      = {hit.negative, hit.center, hit.positive};
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bear_sel   <= 1'b0;
      passed     <= 1'b0;
      bear_ready <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (point_take) begin
            state    <= S_ELEV_START;
            bear_sel <= 1'b0;
          end
        end
        S_ELEV_START: begin
          state <= S_ELEV_WAIT;
        end
        S_ELEV_WAIT: begin
          if (cordic_done) begin
            if (cordic_angle >= min_elev_s) begin
              passed   <= 1'b1;
              bear_sel <= 1'b1;
              state    <= S_BEAR_START;
            end else begin
              passed <= 1'b0;
              state  <= S_UPDATE;
            end
          end
        end
        S_BEAR_START: begin
          bear_ready <= 1'b0;
          state      <= S_BEAR_WAIT;
        end
        S_BEAR_WAIT: begin
          if (cordic_done) begin
            bear_ready <= 1'b1;
          end
          if ((cordic_done || bear_ready) && root_valid) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state <= last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (result_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Point registers and the captured bearing.
  always_ff @(posedge clk) begin
    if (point_take) begin
      px   <= point_x;
      py   <= point_y;
      pz   <= point_z;
      last <= last_point;
    end
    if ((state == S_BEAR_WAIT) && cordic_done) begin
      bearing <= cordic_angle;
    end
  end

  // Sector minima: a strictly smaller range replaces the kept one; emitting clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_seen <= '0;
      for (int k = 0; k < 3; k++) begin
        sector_minimum[k] <= '1;
      end
    end else if ((state == S_UPDATE) && passed) begin
      for (int k = 0; k < 3; k++) begin
        if (hit_vec[k] && (!sector_seen[k] || (root_range < sector_minimum[k]))) begin
          sector_minimum[k] <= root_range;
          sector_seen[k]    <= 1'b1;
        end
      end
    end else if ((state == S_EMIT) && result_free) begin
      sector_seen <= '0;
      for (int k = 0; k < 3; k++) begin
        sector_minimum[k] <= '1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_EMIT) && result_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && result_free) begin
      positive_range <= sector_minimum[0];
      positive_found <= sector_seen[0];
      center_range   <= sector_minimum[1];
      center_found   <= sector_seen[1];
      negative_range <= sector_minimum[2];
      negative_found <= sector_seen[2];
    end
  end

endmodule

@@ rtl/core/snpt_cordic.sv @@
// Iterative vectoring CORDIC that returns atan2(a, b) as a saturated Q2.13 angle.
module snpt_cordic import snpt_pkg::*; #(
  parameter int W = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [W-1:0]       a,
  input  logic signed [W-1:0]       b,
  output logic                      done,
  output logic signed [ANGLE_W-1:0] angle
);

  localparam int XW = W + CORDIC_EXTRA;

  logic                      busy;
  logic                      fin;
  logic                      zero_in;
  logic [STEP_W-1:0]         step;
  logic signed [XW-1:0]      xr;
  logic signed [XW-1:0]      yr;
  logic signed [PHASE_W-1:0] zr;

  logic signed [XW-1:0]      ax;
  logic signed [XW-1:0]      bx;
  logic signed [XW-1:0]      x0;
  logic signed [XW-1:0]      y0;
  logic signed [PHASE_W-1:0] z0;
  logic signed [XW-1:0]      dx;
  logic signed [XW-1:0]      dy;
  logic signed [PHASE_W-1:0] zround;
  logic signed [PHASE_W-1:0] zsat;

  // Scale the inputs and fold a vector with negative cosine side into the right half plane.
  always_comb begin
    ax = {{(XW-W){a[W-1]}}, a} <<< GUARD_SHIFT;
    bx = {{(XW-W){b[W-1]}}, b} <<< GUARD_SHIFT;
    x0 = bx;
    y0 = ax;
    z0 = '0;
    if (bx < 0) begin
      if (ax >= 0) begin
        x0 = ax;
        y0 = -bx;
        z0 = HALF_PI_Q16;
      end else begin
        x0 = -ax;
        y0 = bx;
        z0 = -HALF_PI_Q16;
      end
    end
  end

  // Shared shifter for one micro-rotation.
  assign dx = xr >>> step;
  assign dy = yr >>> step;

  // Round the Q.16 phase half up to Q2.13 and saturate to plus or minus pi.
  always_comb begin
    zround = (zr + PHASE_W'(4)) >>> 3;
    zsat = zround;
    if (zround > PHASE_W'(PI_Q13)) begin
      zsat = PHASE_W'(PI_Q13);
    end else if (zround < -PHASE_W'(PI_Q13)) begin
      zsat = -PHASE_W'(PI_Q13);
    end
  end

  // Control of the iteration loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath of the micro-rotations.
  always_ff @(posedge clk) begin
    if (start) begin
      xr      <= x0;
      yr      <= y0;
      zr      <= z0;
      zero_in <= (a == '0) && (b == '0);
    end else if (busy) begin
      if (yr >= 0) begin
        xr <= xr + dy;
        yr <= yr - dx;
        zr <= zr + atan_q16(step);
      end else begin
        xr <= xr - dy;
        yr <= yr + dx;
        zr <= zr - atan_q16(step);
      end
    end
    if (fin) begin
      angle <= zero_in ? '0 : zsat[ANGLE_W-1:0];
    end
  end

endmodule

@@ rtl/core/snpt_sqrt.sv @@
// Rounded horizontal range: one shared squarer, then a digit-by-digit square root.
module snpt_sqrt import snpt_pkg::*; #(
  parameter int W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic               valid,
  output logic [W-1:0]       range
);

  localparam int SW = 2 * W;
  localparam int RW = W + 3;
  localparam int CW = $clog2(W);

  localparam logic [2:0] P_IDLE  = 3'd0;
  localparam logic [2:0] P_SQA   = 3'd1;
  localparam logic [2:0] P_SQB   = 3'd2;
  localparam logic [2:0] P_ROOT  = 3'd3;
  localparam logic [2:0] P_ROUND = 3'd4;

  logic [2:0]    phase;
  logic [CW-1:0] cnt;
  logic [W-1:0]  ua;
  logic [W-1:0]  ub;
  logic [SW-1:0] sq;
  logic [RW-1:0] rem;
  logic [W-1:0]  root;

  logic [W-1:0]  mul_op;
  logic [SW-1:0] prod;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;

  // One squarer, used for each coordinate in turn.
  assign mul_op = (phase == P_SQA) ? ua : ub;
  assign prod   = SW'(mul_op) * SW'(mul_op);

  // One result bit per step.
  assign rem_sh = {rem[RW-3:0], sq[SW-1 -: 2]};
  assign trial  = (RW'(root) << 2) | RW'(1);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      valid <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            phase <= P_SQA;
            valid <= 1'b0;
          end
        end
        P_SQA: begin
          phase <= P_SQB;
        end
        P_SQB: begin
          phase <= P_ROOT;
          cnt   <= '0;
        end
        P_ROOT: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(W - 1)) begin
            phase <= P_ROUND;
          end
        end
        P_ROUND: begin
          phase <= P_IDLE;
          valid <= 1'b1;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
      if (start && (phase != P_IDLE)) begin
        phase <= P_SQA;
        valid <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      ua <= a[W-1] ? W'(-a) : W'(a);
      ub <= b[W-1] ? W'(-b) : W'(b);
    end
    unique case (phase)
      P_SQA: begin
        sq <= prod;
      end
      P_SQB: begin
        sq   <= sq + prod;
        rem  <= '0;
        root <= '0;
      end
      P_ROOT: begin
        sq <= sq << 2;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[W-2:0], 1'b0};
        end
      end
      P_ROUND: begin
        range <= (rem > RW'(root)) ? root + W'(1) : root;
      end
      default: begin
      end
    endcase
  end

endmodule
